/* rtl/rss_pkg.sv */
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types and constants for the random subset sampler: request and
// result payloads, opcodes, register indexes and the modulo unit status.
// ----------------------------------------------------------------------------
package rss_pkg;

	// payload widths fixed by the interface
	localparam int WORD_W = 31;
	localparam int SLOT_W = 6;
	localparam int CFG_W  = 7;

	// request opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_DRAW  = 1'b1;

	// configuration register indexes
	localparam logic REG_POP_SIZE    = 1'b0;
	localparam logic REG_SUBSET_SIZE = 1'b1;

	typedef struct packed {
		logic              op;
		logic [WORD_W-1:0] random_word;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0] picked_index;
		logic              last;
	} out_item_t;

	// status of the serial modulo unit
	typedef struct packed {
		logic busy;
		logic done;
	} mod_status_t;

endpackage

/* rtl/rss_ram.sv */
// ----------------------------------------------------------------------------
// rss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rss_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rss_mod_unit.sv */
// ----------------------------------------------------------------------------
// rss_mod_unit
// Serial restoring modulo: one dividend bit per cycle, one shared
// compare and subtract against the divisor.
// ----------------------------------------------------------------------------
module rss_mod_unit
	import rss_pkg::*;
#(
	parameter int DVD_W = 31,
	parameter int DIV_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output mod_status_t      status,
	output logic [DIV_W-1:0] remainder
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DVD_W-1:0] dvd_q;
	logic [DIV_W-1:0] div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             fits;

	// shift in the next dividend bit and try the subtract
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = trial >= {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

/* rtl/random_subset_sampler.sv */
// ----------------------------------------------------------------------------
// random_subset_sampler
// Draws a subset of distinct indices from 0..n-1 by partial Fisher-Yates
// shuffling driven by externally supplied random words.
// ----------------------------------------------------------------------------
// A start request latches the population size n (saturated to POP_MAX) and
// the subset size r (clamped to n) and resets the slot table.
// When r < n/2 (rounded down) each draw request yields one index, the r-th flagged last.
// Otherwise each draw request removes one slot silently, and the request
// that brings the remaining count down to r streams out slots 0..r-1, the
// final one flagged last; a start with r equal to n streams them at once.
// Draw requests after the subset is complete are taken and give nothing.
// A draw request that yields an index reduces the random word modulo the
// remaining count in a serial unit, one bit per cycle, then makes two reads
// and one write of the slot RAM (one read port, one write port) and waits
// for the output register to be free; a silent removal skips that wait.
// Kept slots stream out with one read and one output load per index, each
// load waiting on any output stall. Requests are not taken while a draw is in
// progress. Configuration writes are accepted in any cycle and take effect
// at the next start.
// ----------------------------------------------------------------------------
module random_subset_sampler
	import rss_pkg::*;
#(
	parameter int POP_MAX     = 64,
	parameter int RANDOM_BITS = 31
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int EDGE_W = $clog2(POP_MAX + 1);
	localparam int IDX_W  = $clog2(POP_MAX);

	// sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DIV      = 3'd1;
	localparam logic [2:0] S_RD_PICK  = 3'd2;
	localparam logic [2:0] S_RD_LAST  = 3'd3;
	localparam logic [2:0] S_WR       = 3'd4;
	localparam logic [2:0] S_PUT      = 3'd5;
	localparam logic [2:0] S_EMIT_RD  = 3'd6;
	localparam logic [2:0] S_EMIT_PUT = 3'd7;

	localparam logic [CFG_W-1:0] POP_MAX_C = CFG_W'(POP_MAX);

	logic [2:0]        state_q;
	logic [CFG_W-1:0]  pop_size_q;
	logic [CFG_W-1:0]  subset_size_q;
	logic [EDGE_W-1:0] edge_q;
	logic [EDGE_W-1:0] subset_q;
	logic [EDGE_W-1:0] picks_q;
	logic [EDGE_W-1:0] emit_cnt_q;
	logic              keep_mode_q;
	logic              finished_q;
	logic [IDX_W-1:0]  pick_q;
	logic [SLOT_W-1:0] taken_q;
	logic [POP_MAX-1:0] written_q;
	logic              rd_written_q;
	logic [IDX_W-1:0]  rd_addr_q;
	logic              out_valid_q;
	out_item_t         out_data_q;

	logic              in_acc;
	logic              out_free;
	logic              out_load;
	out_item_t         out_next;
	logic [CFG_W-1:0]  n_sat;
	logic [CFG_W-1:0]  r_clamp;
	logic              keep_start;
	logic [EDGE_W-1:0] edge_dec;
	logic [32:0]       word_ext;
	logic              mod_start;
	mod_status_t       mod_stat;
	logic [EDGE_W-1:0] mod_rem;
	logic              ram_we;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	logic [SLOT_W-1:0] ram_rdata;
	logic [SLOT_W-1:0] slot_val;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign edge_dec  = edge_q - 1'b1;

	// start-time sizes
	assign n_sat      = (pop_size_q > POP_MAX_C) ? POP_MAX_C : pop_size_q;
	assign r_clamp    = (subset_size_q > n_sat) ? n_sat : subset_size_q;
	assign keep_start = !(r_clamp < (n_sat >> 1));

	// random word zero-extended; the modulo unit takes its low RANDOM_BITS bits
	assign word_ext  = {2'b00, in_data.random_word};
	assign mod_start = in_acc && (in_data.op == OP_DRAW) && !finished_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop_size_q    <= CFG_W'(64);
			subset_size_q <= CFG_W'(8);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_POP_SIZE:    pop_size_q    <= cfg_data;
				REG_SUBSET_SIZE: subset_size_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// serial modulo of the random word by the remaining count
	rss_mod_unit #(
		.DVD_W(RANDOM_BITS),
		.DIV_W(EDGE_W)
	) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (word_ext[RANDOM_BITS-1:0]),
		.divisor  (edge_q),
		.status   (mod_stat),
		.remainder(mod_rem)
	);

	// slot RAM read address per state
	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = pick_q;
		case (state_q)
			S_RD_PICK: begin
				ram_re    = 1'b1;
				ram_raddr = pick_q;
			end
			S_RD_LAST: begin
				ram_re    = 1'b1;
				ram_raddr = edge_dec[IDX_W-1:0];
			end
			S_EMIT_RD: begin
				ram_re    = 1'b1;
				ram_raddr = emit_cnt_q[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	assign ram_we = (state_q == S_WR);

	rss_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(POP_MAX)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pick_q),
		.wdata(slot_val),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// track flag and address of the outstanding read
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_written_q <= written_q[ram_raddr];
			rd_addr_q    <= ram_raddr;
		end
	end

	// unwritten slot reads as its own index
	assign slot_val = rd_written_q ? ram_rdata : SLOT_W'(rd_addr_q);

	// written flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (in_acc && (in_data.op == OP_START)) begin
			written_q <= '0;
		end else if (ram_we) begin
			written_q[pick_q] <= 1'b1;
		end
	end

	// result to load into the output register
	always_comb begin
		out_load = 1'b0;
		out_next = out_data_q;
		if (state_q == S_PUT && out_free) begin
			out_load              = 1'b1;
			out_next.picked_index = taken_q;
			out_next.last         = (picks_q + 1'b1) >= subset_q;
		end else if (state_q == S_EMIT_PUT && out_free) begin
			out_load              = 1'b1;
			out_next.picked_index = slot_val;
			out_next.last         = (emit_cnt_q + 1'b1) == subset_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= out_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			edge_q      <= '0;
			subset_q    <= '0;
			picks_q     <= '0;
			emit_cnt_q  <= '0;
			keep_mode_q <= 1'b0;
			finished_q  <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && in_data.op == OP_START) begin
						edge_q      <= EDGE_W'(n_sat);
						subset_q    <= EDGE_W'(r_clamp);
						picks_q     <= '0;
						emit_cnt_q  <= '0;
						keep_mode_q <= keep_start;
						finished_q  <= 1'b0;
						if (keep_start && n_sat <= r_clamp) begin
							if (r_clamp == '0) begin
								finished_q <= 1'b1;
							end else begin
								state_q <= S_EMIT_RD;
							end
						end else if (!keep_start && r_clamp == '0) begin
							finished_q <= 1'b1;
						end
					end else if (mod_start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (mod_stat.done) begin
						state_q <= S_RD_PICK;
					end
				end
				S_RD_PICK: begin
					state_q <= S_RD_LAST;
				end
				S_RD_LAST: begin
					state_q <= S_WR;
				end
				S_WR: begin
					edge_q <= edge_dec;
					if (!keep_mode_q) begin
						state_q <= S_PUT;
					end else if (edge_dec <= subset_q) begin
						// an empty subset ends the draw with nothing to stream
						if (subset_q == '0) begin
							finished_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							emit_cnt_q <= '0;
							state_q    <= S_EMIT_RD;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_PUT: begin
					if (out_load) begin
						picks_q <= picks_q + 1'b1;
						if (out_next.last) begin
							finished_q <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_PUT;
				end
				S_EMIT_PUT: begin
					if (out_load) begin
						if (out_next.last) begin
							finished_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							emit_cnt_q <= emit_cnt_q + 1'b1;
							state_q    <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pick index and taken value
	always_ff @(posedge clk) begin
		if (state_q == S_DIV && mod_stat.done) begin
			pick_q <= mod_rem[IDX_W-1:0];
		end
		if (state_q == S_RD_LAST) begin
			taken_q <= slot_val;
		end
	end

	// the modulo result always lands inside the live slots
	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && mod_stat.done) |-> (mod_rem < edge_q))
		else $error("modulo result outside remaining slots");

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten");

	// a removal always has a slot to remove
	a_edge_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |-> (edge_q != '0))
		else $error("slot removal with no slots left");

	// pick count never passes the subset size
	a_picks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		picks_q <= subset_q)
		else $error("pick count exceeds subset size");

endmodule
